/* hdl/dc_link_voltage_supervisor_defines.svh */
// Assertion macros for the DC-link voltage supervisor checker.
// Pulled in by the checker file only; depends on nothing else.
`ifndef DC_LINK_VOLTAGE_SUPERVISOR_DEFINES_SVH
`define DC_LINK_VOLTAGE_SUPERVISOR_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define DLVS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DLVS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dlvs_pkg.sv */
// Shared types and constants of the DC-link voltage supervisor.
// No dependencies; compiled before the interfaces and all modules.
`default_nettype none

package dlvs_pkg;

    localparam int SPP_W   = 8;
    localparam int VOLT_W  = 10;
    localparam int TIME_W  = 32;
    localparam int CFG_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_CHECK  = 1'b1;

    typedef enum logic [2:0] {
        REG_SPP       = 3'd0,
        REG_VSCALE    = 3'd1,
        REG_UNDER_LIM = 3'd2,
        REG_UNDER_HYS = 3'd3,
        REG_UNDER_TO  = 3'd4,
        REG_OVER_LIM  = 3'd5,
        REG_OVER_HYS  = 3'd6,
        REG_OVER_TO   = 3'd7
    } t_reg_idx;

    localparam logic [SPP_W-1:0]  RST_SPP       = 8'd25;
    localparam logic [VOLT_W-1:0] RST_VSCALE    = 10'd400;
    localparam logic [VOLT_W-1:0] RST_UNDER_LIM = 10'd150;
    localparam logic [VOLT_W-1:0] RST_UNDER_HYS = 10'd10;
    localparam logic [TIME_W-1:0] RST_UNDER_TO  = 32'd100;
    localparam logic [VOLT_W-1:0] RST_OVER_LIM  = 10'd420;
    localparam logic [VOLT_W-1:0] RST_OVER_HYS  = 10'd10;
    localparam logic [TIME_W-1:0] RST_OVER_TO   = 32'd100;

    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

    typedef struct packed {
        logic [SPP_W-1:0]  spp;
        logic [VOLT_W-1:0] vscale;
        logic [VOLT_W-1:0] under_lim;
        logic [VOLT_W-1:0] under_hys;
        logic [TIME_W-1:0] under_to;
        logic [VOLT_W-1:0] over_lim;
        logic [VOLT_W-1:0] over_hys;
        logic [TIME_W-1:0] over_to;
    } t_cfg;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic valid;
        logic is_check;
    } t_q_head;

endpackage

`default_nettype wire

/* hdl/dlvs_if.sv */
// Valid/ready channel interfaces for input words and result words.
// No dependencies beyond the language; compiled after the package.
`default_nettype none

interface dlvs_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [31:0]            now_time;

    modport source (output valid, action, adc_sample, now_time, input ready);
    modport sink   (input valid, action, adc_sample, now_time, output ready);
endinterface

interface dlvs_out_if;
    logic       valid;
    logic       ready;
    logic       period_done;
    logic [9:0] mean_volts;
    logic [9:0] peak_volts;
    logic       under_mode;
    logic       over_mode;
    logic       fault;

    modport source (output valid, period_done, mean_volts, peak_volts, under_mode,
                    over_mode, fault, input ready);
    modport sink   (input valid, period_done, mean_volts, peak_volts, under_mode,
                    over_mode, fault, output ready);
endinterface

`default_nettype wire

/* hdl/dlvs_front.sv */
// Front end: takes input words, tags them sample or check, queues them.
// Depends on dlvs_pkg and dlvs_in_if.
`default_nettype none

module dlvs_front
    import dlvs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dlvs_in_if.sink                i_item,
    output t_q_head                o_head,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic [TIME_W-1:0]      o_now,
    input  logic                   i_pop
);

    localparam int DEPTH = 2;

    logic                   r_is_check [DEPTH];
    logic [SAMPLE_BITS-1:0] r_sample   [DEPTH];
    logic [TIME_W-1:0]      r_now      [DEPTH];
    logic                   r_wr_ptr, n_wr_ptr;
    logic                   r_rd_ptr, n_rd_ptr;
    logic [1:0]             r_count, n_count;
    logic                   push;

    assign i_item.ready = (r_count != 2'(DEPTH));
    assign push         = i_item.valid && i_item.ready;

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_is_check[r_wr_ptr] <= (i_item.action == ACTION_CHECK);
            r_sample[r_wr_ptr]   <= i_item.adc_sample;
            r_now[r_wr_ptr]      <= i_item.now_time;
        end
    end

    assign o_head.valid    = (r_count != 2'd0);
    assign o_head.is_check = r_is_check[r_rd_ptr];
    assign o_sample        = r_sample[r_rd_ptr];
    assign o_now           = r_now[r_rd_ptr];

endmodule

`default_nettype wire

/* hdl/dlvs_back.sv */
// Back end: period accumulation, serial divide, volts scaling, fault checks,
// and the result register. Depends on dlvs_pkg and dlvs_out_if.
`default_nettype none

module dlvs_back
    import dlvs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int Q_SHIFT     = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_q_head                i_head,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TIME_W-1:0]      i_now,
    output logic                   o_pop,
    dlvs_out_if.source             o_res
);

    localparam int SUM_W  = SAMPLE_BITS + 8;
    localparam int DIVR_W = SPP_W + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int PROD_W = SUM_W + VOLT_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MULM = 5'b00100,
        ST_MULP = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [SPP_W-1:0]       r_left, n_left;
    logic [SAMPLE_BITS-1:0] r_peak, n_peak;
    logic [VOLT_W-1:0]      r_mean, n_mean;
    logic [VOLT_W-1:0]      r_peakv, n_peakv;
    logic                   r_ul, n_ul, r_ua, n_ua;
    logic                   r_ol, n_ol, r_oa, n_oa;
    logic [TIME_W-1:0]      r_us, n_us, r_os, n_os;

    logic [DIVR_W-1:0]      r_div, n_div;
    logic [DIVR_W-1:0]      r_rem, n_rem;
    logic [SUM_W-1:0]       r_quo, n_quo;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [SAMPLE_BITS-1:0] r_peak_hold, n_peak_hold;
    logic [PROD_W-1:0]      r_prod, n_prod;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_done, n_out_done;
    logic [VOLT_W-1:0]      r_out_mean, n_out_mean;
    logic [VOLT_W-1:0]      r_out_peak, n_out_peak;
    logic                   r_out_u, n_out_u;
    logic                   r_out_o, n_out_o;

    logic                   out_free;
    logic [SUM_W-1:0]       sum_add;
    logic [SAMPLE_BITS-1:0] peak_new;
    logic [SPP_W-1:0]       left_dec;
    logic [DIVR_W:0]        trial;
    logic                   trial_ge;
    logic [VOLT_W:0]        u_thr;
    logic [TIME_W-1:0]      u_elapsed, o_elapsed;
    logic signed [VOLT_W+1:0] o_rec, v_s;

    function automatic logic [VOLT_W-1:0] sat_volts(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] sh;
        sh = p >> Q_SHIFT;
        return (|sh[PROD_W-1:VOLT_W]) ? VOLT_MAX : sh[VOLT_W-1:0];
    endfunction

    assign out_free  = !r_out_valid || o_res.ready;
    assign sum_add   = r_sum + SUM_W'(i_sample);
    assign peak_new  = (i_sample > r_peak) ? i_sample : r_peak;
    assign left_dec  = r_left - SPP_W'(1);
    assign trial     = {r_rem, r_quo[SUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_div});
    assign u_thr     = {1'b0, i_cfg.under_lim} + {1'b0, i_cfg.under_hys};
    assign u_elapsed = i_now - r_us;
    assign o_elapsed = i_now - r_os;
    assign o_rec     = $signed({2'b00, i_cfg.over_lim}) - $signed({2'b00, i_cfg.over_hys});
    assign v_s       = $signed({2'b00, r_mean});

    always_comb begin
        logic load_out;
        logic done;
        n_state     = r_state;
        n_sum       = r_sum;
        n_left      = r_left;
        n_peak      = r_peak;
        n_mean      = r_mean;
        n_peakv     = r_peakv;
        n_ul        = r_ul;
        n_ua        = r_ua;
        n_us        = r_us;
        n_ol        = r_ol;
        n_oa        = r_oa;
        n_os        = r_os;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_peak_hold = r_peak_hold;
        n_prod      = r_prod;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        done        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.is_check) begin
                        // undervoltage first
                        if ({1'b0, r_mean} > u_thr) begin
                            n_ul = 1'b0;
                            n_ua = 1'b1;
                        end else if (r_mean < i_cfg.under_lim) begin
                            if (r_ua) begin
                                n_us = i_now;
                                n_ua = 1'b0;
                            end else if (u_elapsed > i_cfg.under_to) begin
                                n_ul = 1'b1;
                            end
                        end
                        // overvoltage only while no undervoltage is latched
                        if (!n_ul) begin
                            if (v_s < o_rec) begin
                                n_ol = 1'b0;
                                n_oa = 1'b1;
                            end else if (r_mean > i_cfg.over_lim) begin
                                if (r_oa) begin
                                    n_os = i_now;
                                    n_oa = 1'b0;
                                end else if (o_elapsed > i_cfg.over_to) begin
                                    n_ol = 1'b1;
                                end
                            end
                        end
                        load_out = 1'b1;
                    end else if (left_dec == '0) begin
                        // close the period: divisor 0 means 256
                        n_quo       = sum_add;
                        n_peak_hold = peak_new;
                        n_div       = (i_cfg.spp == '0) ? DIVR_W'(256)
                                                        : {1'b0, i_cfg.spp};
                        n_rem       = '0;
                        n_cnt       = CNT_W'(SUM_W);
                        n_sum       = '0;
                        n_peak      = '0;
                        n_left      = i_cfg.spp;
                        n_state     = ST_DIV;
                    end else begin
                        n_sum    = sum_add;
                        n_peak   = peak_new;
                        n_left   = left_dec;
                        load_out = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle, restoring
                if (trial_ge) begin
                    n_rem = DIVR_W'(trial - {1'b0, r_div});
                end else begin
                    n_rem = trial[DIVR_W-1:0];
                end
                n_quo = {r_quo[SUM_W-2:0], trial_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_MULM;
                end
            end
            ST_MULM: begin
                n_prod  = PROD_W'(r_quo) * PROD_W'(i_cfg.vscale);
                n_state = ST_MULP;
            end
            ST_MULP: begin
                n_mean  = sat_volts(r_prod);
                n_prod  = PROD_W'(r_peak_hold) * PROD_W'(i_cfg.vscale);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_peakv  = sat_volts(r_prod);
                    load_out = 1'b1;
                    done     = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !o_res.ready;
        n_out_done  = r_out_done;
        n_out_mean  = r_out_mean;
        n_out_peak  = r_out_peak;
        n_out_u     = r_out_u;
        n_out_o     = r_out_o;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_done  = done;
            n_out_mean  = n_mean;
            n_out_peak  = n_peakv;
            n_out_u     = n_ul;
            n_out_o     = n_ol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_left      <= RST_SPP;
            r_peak      <= '0;
            r_mean      <= '0;
            r_peakv     <= '0;
            r_ul        <= 1'b0;
            r_ua        <= 1'b0;
            r_us        <= '0;
            r_ol        <= 1'b0;
            r_oa        <= 1'b0;
            r_os        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_left      <= n_left;
            r_peak      <= n_peak;
            r_mean      <= n_mean;
            r_peakv     <= n_peakv;
            r_ul        <= n_ul;
            r_ua        <= n_ua;
            r_us        <= n_us;
            r_ol        <= n_ol;
            r_oa        <= n_oa;
            r_os        <= n_os;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_peak_hold <= n_peak_hold;
        r_prod      <= n_prod;
        r_out_done  <= n_out_done;
        r_out_mean  <= n_out_mean;
        r_out_peak  <= n_out_peak;
        r_out_u     <= n_out_u;
        r_out_o     <= n_out_o;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.period_done = r_out_done;
    assign o_res.mean_volts  = r_out_mean;
    assign o_res.peak_volts  = r_out_peak;
    assign o_res.under_mode  = r_out_u;
    assign o_res.over_mode   = r_out_o;
    assign o_res.fault       = r_out_u || r_out_o;

endmodule

`default_nettype wire

/* hdl/dc_link_voltage_supervisor.sv */
// Top level of the DC-link voltage supervisor: register file, front, back.
// Depends on dlvs_pkg, dlvs_if, dlvs_front and dlvs_back.
//
//   Channel  Dir  Handshake              Carries
//   i_item   in   valid/ready            action, adc_sample, now_time
//   o_res    out  valid/ready            period_done, volts, modes, fault
//   APB      in   psel/penable, pready   eight setup registers at 4*index
//
// A check word or a sample that does not close a period is handled in the
// idle state of the back end. A sample that closes a period goes through
// accumulation, the restoring serial divider, the scaling multiplier for the
// mean and then the peak, saturation, and the result register.
// The two-word input queue takes words while the back end is busy, until full;
// a held result only stalls the back end. Synchronous reset, no clearing pass.
`default_nettype none

module dc_link_voltage_supervisor
    import dlvs_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int Q_SHIFT     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlvs_in_if.sink           i_item,
    dlvs_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg                   r_cfg, n_cfg;
    t_q_head                head;
    logic [SAMPLE_BITS-1:0] q_sample;
    logic [TIME_W-1:0]      q_now;
    logic                   pop;
    logic                   wr_en;
    t_reg_idx               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_SPP:       n_cfg.spp       = pwdata[SPP_W-1:0];
                REG_VSCALE:    n_cfg.vscale    = pwdata[VOLT_W-1:0];
                REG_UNDER_LIM: n_cfg.under_lim = pwdata[VOLT_W-1:0];
                REG_UNDER_HYS: n_cfg.under_hys = pwdata[VOLT_W-1:0];
                REG_UNDER_TO:  n_cfg.under_to  = pwdata[TIME_W-1:0];
                REG_OVER_LIM:  n_cfg.over_lim  = pwdata[VOLT_W-1:0];
                REG_OVER_HYS:  n_cfg.over_hys  = pwdata[VOLT_W-1:0];
                REG_OVER_TO:   n_cfg.over_to   = pwdata[TIME_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPP:       prdata = APB_DW'(r_cfg.spp);
            REG_VSCALE:    prdata = APB_DW'(r_cfg.vscale);
            REG_UNDER_LIM: prdata = APB_DW'(r_cfg.under_lim);
            REG_UNDER_HYS: prdata = APB_DW'(r_cfg.under_hys);
            REG_UNDER_TO:  prdata = r_cfg.under_to;
            REG_OVER_LIM:  prdata = APB_DW'(r_cfg.over_lim);
            REG_OVER_HYS:  prdata = APB_DW'(r_cfg.over_hys);
            REG_OVER_TO:   prdata = r_cfg.over_to;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spp       <= RST_SPP;
            r_cfg.vscale    <= RST_VSCALE;
            r_cfg.under_lim <= RST_UNDER_LIM;
            r_cfg.under_hys <= RST_UNDER_HYS;
            r_cfg.under_to  <= RST_UNDER_TO;
            r_cfg.over_lim  <= RST_OVER_LIM;
            r_cfg.over_hys  <= RST_OVER_HYS;
            r_cfg.over_to   <= RST_OVER_TO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dlvs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_head   (head),
        .o_sample (q_sample),
        .o_now    (q_now),
        .i_pop    (pop)
    );

    dlvs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .Q_SHIFT     (Q_SHIFT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_sample (q_sample),
        .i_now    (q_now),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

/* hdl/dlvs_checker.sv */
// Port-level checker for the DC-link voltage supervisor, bound to the top.
// Depends on dc_link_voltage_supervisor_defines.svh.
`default_nettype none
`include "dc_link_voltage_supervisor_defines.svh"

module dlvs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_done,
    input logic [9:0] i_mean,
    input logic [9:0] i_peak,
    input logic       i_under,
    input logic       i_over,
    input logic       i_fault
);

    // hold a stalled result word
    `DLVS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_done) && $stable(i_mean) && $stable(i_peak) && $stable(i_fault), "result word changed while stalled")

    // come out of reset with room in the queue and no result pending
    `DLVS_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "not empty after reset")

    `DLVS_ASSERT(a_fault_or, i_clk, i_rst_n, i_out_valid |-> (i_fault == (i_under || i_over)), "fault does not match the mode flags")

endmodule

bind dc_link_voltage_supervisor dlvs_checker u_dlvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_done      (o_res.period_done),
    .i_mean      (o_res.mean_volts),
    .i_peak      (o_res.peak_volts),
    .i_under     (o_res.under_mode),
    .i_over      (o_res.over_mode),
    .i_fault     (o_res.fault)
);

`default_nettype wire
